FILE: design/taylor_series_evaluator_top_defines.svh
// Assertion helpers used by taylor_series_evaluator_top.
`ifndef TAYLOR_SERIES_EVALUATOR_TOP_DEFINES_SVH
`define TAYLOR_SERIES_EVALUATOR_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TSE_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TSE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/tse_pkg.sv
`default_nettype none

package tse_pkg;

  // Largest number of series terms that one evaluation sums.
  localparam int MAX_TERMS = 64;

  // Field and register widths.
  localparam int X_W    = 32;
  localparam int RES_W  = 48;
  localparam int FSEL_W = 3;
  localparam int NT_W   = 7;
  localparam int CFG_W  = 7;
  localparam int IDX_W  = 1;

  // Internal widths.
  localparam int MAG_W  = 47;                // term magnitude
  localparam int M_W    = 39;                // multiplier magnitude, up to 2^38
  localparam int FRAC_W = 24;                // fraction bits of Q24.24
  localparam int MUL_W  = 32;                // shared multiplier operand width
  localparam int PROD_W = 2 * MUL_W;
  localparam int DVD_W  = 64;                // dividend and quotient width
  localparam int DIV_BITS  = 4;              // quotient bits per divider cycle
  localparam int DIV_STEPS = DVD_W / DIV_BITS;
  localparam int DCNT_W    = $clog2(DIV_STEPS);
  localparam int K_W    = $clog2(MAX_TERMS);
  localparam int DA_W   = K_W + 2;
  localparam int D_W    = $clog2(2 * MAX_TERMS * (2 * MAX_TERMS - 1));
  localparam int SUMX_W = RES_W + 2;

  // Fixed point constants.
  localparam logic [MAG_W-1:0] MAG_MAX = {MAG_W{1'b1}};
  localparam logic [RES_W-1:0] ONE_Q24 = RES_W'(1) << FRAC_W;
  localparam logic signed [SUMX_W-1:0] SUM_MAX = SUMX_W'((64'd1 << (RES_W - 1)) - 64'd1);
  localparam logic signed [SUMX_W-1:0] SUM_MIN = -SUMX_W'(64'd1 << (RES_W - 1));

  // Function codes.
  localparam logic [FSEL_W-1:0] FN_SIN  = 3'd0;
  localparam logic [FSEL_W-1:0] FN_EXP  = 3'd1;
  localparam logic [FSEL_W-1:0] FN_COS  = 3'd2;
  localparam logic [FSEL_W-1:0] FN_SINH = 3'd3;
  localparam logic [FSEL_W-1:0] FN_COSH = 3'd4;
  localparam logic [FSEL_W-1:0] FN_SINC = 3'd5;

  // Configuration register indexes.
  localparam logic [IDX_W-1:0] REG_FSEL  = 1'd0;
  localparam logic [IDX_W-1:0] REG_NTERM = 1'd1;

  // Reset values of the configuration registers.
  localparam logic [FSEL_W-1:0] FSEL_RESET  = FN_SIN;
  localparam logic [NT_W-1:0]   NTERM_RESET = 7'd8;

endpackage

`default_nettype wire

FILE: design/taylor_series_evaluator_top.sv
// Unused function codes give zero and sin(x)/x at zero gives one without a series. Each further
// term takes four partial products on the shared 32x32 multiplier, sixteen 4-bit divider steps
// and then setup, saturation and accumulation. A new input is accepted only when idle, after
// the previous result has entered the output register; a held output register delays that.
// Reset (synchronous, active high) idles the sequencer, empties the output register and sets
// function_select to sin and term_count to 8.
`default_nettype none

module taylor_series_evaluator_top
  import tse_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  // Configuration write port.
  input  wire logic                 cfg_we,
  input  wire logic [IDX_W-1:0]     cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data,
  // Input stream.
  input  wire logic                 s_axis_tvalid,
  output logic                      s_axis_tready,
  input  wire logic [X_W-1:0]       s_axis_tdata,   // [31:0] x_value
  // Output stream.
  output logic                      m_axis_tvalid,
  input  wire logic                 m_axis_tready,
  output logic [RES_W-1:0]          m_axis_tdata,   // [47:0] series_result
  output logic [0:0]                m_axis_tuser    // [0] overflow
);

  `include "taylor_series_evaluator_top_defines.svh"

  typedef enum logic [3:0] {
    S_IDLE, S_SETUP, S_SQ, S_SQW, S_LOOP, S_MUL, S_MULW, S_DIV, S_SAT, S_SUM, S_OUT
  } state_t;

  state_t              state;
  logic [FSEL_W-1:0]   function_select;
  logic [NT_W-1:0]     term_count;
  logic [FSEL_W-1:0]   fsel;
  logic [NT_W-1:0]     nterm;
  logic                xneg;
  logic [X_W-1:0]      xmag;
  logic [M_W-1:0]      m;
  logic                mneg;
  logic [MAG_W-1:0]    tmag;
  logic                tneg;
  logic [RES_W-1:0]    sum;
  logic                ovf;
  logic [K_W-1:0]      k;
  logic [D_W-1:0]      d;
  logic [1:0]          ph;
  logic [PROD_W-1:0]   prod;
  logic [DVD_W-1:0]    acc;
  logic [DVD_W-1:0]    dvd;
  logic [DVD_W-1:0]    quot;
  logic [D_W-1:0]      rem;
  logic [DCNT_W-1:0]   dcnt;

  logic [MUL_W-1:0]    mul_a;
  logic [MUL_W-1:0]    mul_b;
  logic [PROD_W-1:0]   mul_p;
  logic [1:0]          acc_idx;
  logic [DVD_W-1:0]    acc_next;
  logic [D_W-1:0]      rem_next;
  logic [DIV_BITS-1:0] qdig;
  logic [DA_W-1:0]     da;
  logic [2*DA_W-1:0]   dprod;
  logic [D_W-1:0]      dcalc;
  logic signed [SUMX_W-1:0] term_s;
  logic signed [SUMX_W-1:0] sum_ext;
  logic                sum_last;

  assign s_axis_tready = (state == S_IDLE);

  // Operand selection for the shared multiplier.
  always_comb begin
    mul_a = xmag;
    mul_b = xmag;
    if (state == S_MUL) begin
      case (ph)
        2'd0: begin
          mul_a = MUL_W'(tmag[FRAC_W-1:0]);
          mul_b = MUL_W'(m[FRAC_W-1:0]);
        end
        2'd1: begin
          mul_a = MUL_W'(tmag[FRAC_W-1:0]);
          mul_b = MUL_W'(m[M_W-1:FRAC_W]);
        end
        2'd2: begin
          mul_a = MUL_W'(tmag[MAG_W-1:FRAC_W]);
          mul_b = MUL_W'(m[FRAC_W-1:0]);
        end
        default: begin
          mul_a = MUL_W'(tmag[MAG_W-1:FRAC_W]);
          mul_b = MUL_W'(m[M_W-1:FRAC_W]);
        end
      endcase
    end
  end

  assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

  // Partial product accumulation; the low-by-low product is rounded half up into Q.24.
  assign acc_idx = (state == S_MULW) ? 2'd3 : (ph - 2'd1);

  always_comb begin
    case (acc_idx)
      2'd0:    acc_next = acc + DVD_W'(prod[PROD_W-1:FRAC_W]) + DVD_W'(prod[FRAC_W-1]);
      2'd3:    acc_next = acc + {prod[DVD_W-FRAC_W-1:0], {FRAC_W{1'b0}}};
      default: acc_next = acc + prod;
    endcase
  end

  // Divisor for the current term index.
  always_comb begin
    if (fsel == FN_COS || fsel == FN_COSH) begin
      da = {1'b0, k, 1'b0} + DA_W'(1);
    end else begin
      da = {1'b0, k, 1'b0} + DA_W'(2);
    end
    dprod = (2*DA_W)'(da) * (2*DA_W)'(da + DA_W'(1));
    if (fsel == FN_EXP) begin
      dcalc = D_W'(k) + D_W'(1);
    end else begin
      dcalc = dprod[D_W-1:0];
    end
  end

  // Restoring divider, several quotient bits per cycle.
  always_comb begin
    logic [D_W:0] t;
    logic [D_W-1:0] r;
    r    = rem;
    qdig = '0;
    for (int i = 0; i < DIV_BITS; i++) begin
      t = {r, dvd[DVD_W-1-i]};
      if (t >= {1'b0, d}) begin
        r = D_W'(t - {1'b0, d});
        qdig[DIV_BITS-1-i] = 1'b1;
      end else begin
        r = t[D_W-1:0];
      end
    end
    rem_next = r;
  end

  // Signed accumulation of the new term.
  always_comb begin
    if (tneg) begin
      term_s = -$signed(SUMX_W'(tmag));
    end else begin
      term_s = $signed(SUMX_W'(tmag));
    end
    sum_ext = $signed({{2{sum[RES_W-1]}}, sum}) + term_s;
  end

  assign sum_last = (int'(k) + 1 >= int'(nterm));

  // Sequencer, datapath registers and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      m_axis_tvalid   <= 1'b0;
      function_select <= FSEL_RESET;
      term_count      <= NTERM_RESET;
    end else begin
      prod <= mul_p;

      if (cfg_we) begin
        case (cfg_index)
          REG_FSEL:  function_select <= cfg_data[FSEL_W-1:0];
          REG_NTERM: term_count      <= cfg_data[NT_W-1:0];
          default: ;
        endcase
      end

      // The output register empties on a transfer unless a new result replaces it.
      if (m_axis_tvalid && m_axis_tready && state != S_OUT) begin
        m_axis_tvalid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            xneg <= s_axis_tdata[X_W-1];
            xmag <= s_axis_tdata[X_W-1] ? (~s_axis_tdata + X_W'(1)) : s_axis_tdata;
            fsel <= function_select;
            if (term_count == '0) begin
              nterm <= NT_W'(1);
            end else if (int'(term_count) > MAX_TERMS) begin
              nterm <= NT_W'(MAX_TERMS);
            end else begin
              nterm <= term_count;
            end
            state <= S_SETUP;
          end
        end
        S_SETUP: begin
          ovf <= 1'b0;
          k   <= '0;
          if (fsel > FN_SINC) begin
            sum   <= '0;
            state <= S_OUT;
          end else if (fsel == FN_SINC && xmag == '0) begin
            sum   <= ONE_Q24;
            state <= S_OUT;
          end else begin
            if (fsel == FN_SIN || fsel == FN_SINH) begin
              tmag <= MAG_W'(xmag);
              tneg <= xneg;
              sum  <= xneg ? (~RES_W'(xmag) + RES_W'(1)) : RES_W'(xmag);
            end else begin
              tmag <= MAG_W'(ONE_Q24);
              tneg <= 1'b0;
              sum  <= ONE_Q24;
            end
            if (fsel == FN_EXP) begin
              m     <= M_W'(xmag);
              mneg  <= xneg;
              state <= S_LOOP;
            end else begin
              mneg  <= !(fsel == FN_SINH || fsel == FN_COSH);
              state <= S_SQ;
            end
          end
        end
        S_SQ: begin
          state <= S_SQW;
        end
        S_SQW: begin
          // x squared rounded half up to Q.24.
          m     <= M_W'(prod[PROD_W-1:FRAC_W] + (PROD_W-FRAC_W)'(prod[FRAC_W-1]));
          state <= S_LOOP;
        end
        S_LOOP: begin
          if (sum_last) begin
            state <= S_OUT;
          end else begin
            d     <= dcalc;
            acc   <= DVD_W'(dcalc[D_W-1:1]);
            ph    <= '0;
            state <= S_MUL;
          end
        end
        S_MUL: begin
          if (ph != 2'd0) begin
            acc <= acc_next;
          end
          ph <= ph + 2'd1;
          if (ph == 2'd3) begin
            state <= S_MULW;
          end
        end
        S_MULW: begin
          dvd   <= acc_next;
          quot  <= '0;
          rem   <= '0;
          dcnt  <= '0;
          state <= S_DIV;
        end
        S_DIV: begin
          dvd  <= dvd << DIV_BITS;
          quot <= {quot[DVD_W-DIV_BITS-1:0], qdig};
          rem  <= rem_next;
          dcnt <= dcnt + DCNT_W'(1);
          if (dcnt == DCNT_W'(DIV_STEPS - 1)) begin
            state <= S_SAT;
          end
        end
        S_SAT: begin
          if (quot > DVD_W'(MAG_MAX)) begin
            tmag <= MAG_MAX;
            ovf  <= 1'b1;
          end else begin
            tmag <= quot[MAG_W-1:0];
          end
          tneg  <= tneg ^ mneg;
          state <= S_SUM;
        end
        S_SUM: begin
          if (sum_ext > SUM_MAX) begin
            sum <= SUM_MAX[RES_W-1:0];
            ovf <= 1'b1;
          end else if (sum_ext < SUM_MIN) begin
            sum <= SUM_MIN[RES_W-1:0];
            ovf <= 1'b1;
          end else begin
            sum <= sum_ext[RES_W-1:0];
          end
          k     <= k + K_W'(1);
          state <= S_LOOP;
        end
        S_OUT: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tvalid   <= 1'b1;
            m_axis_tdata    <= sum;
            m_axis_tuser[0] <= ovf;
            state           <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // An input transfer always starts a new evaluation.
  `TSE_ASSERT_NEXT(a_accept_starts, s_axis_tvalid && s_axis_tready, state == S_SETUP, "no start")
  // The divider remainder stays below the divisor.
  `TSE_ASSERT_IMP(a_div_rem, state == S_DIV, rem < d, "divider remainder out of range")
  // The divisor is never zero once a term is under way.
  `TSE_ASSERT_IMP(a_div_nonzero, state == S_MUL, d != '0, "zero divisor")
  // The term index never reaches the term count.
  `TSE_ASSERT_IMP(a_term_range, state == S_LOOP, int'(k) < int'(nterm), "term index overran")

endmodule

`default_nettype wire
